@@ rtl/core/cbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbsm_pkg
// Shared types, constants and helpers of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbsm_pkg;

   localparam int RAM_BANKS      = 4;
   localparam int RAM_BANK_BYTES = 8192;
   localparam int ROM_BANK_BYTES = 16384;

   localparam int CMD_W          = 2;
   localparam int ADDR_W         = 16;
   localparam int DATA_W         = 8;
   localparam int CFG_W          = 3;
   localparam int ROM_ADDR_W     = 19;
   localparam int ROM_BANK_W     = 5;
   localparam int ROM_OFFSET_W   = $clog2(ROM_BANK_BYTES);
   localparam int RAM_OFFSET_W   = $clog2(RAM_BANK_BYTES);
   localparam int RAM_BANK_W     = 2;
   localparam int RAM_SEL_W      = $clog2(RAM_BANKS);
   localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
   localparam int RAM_INDEX_W    = $clog2(RAM_DEPTH);

   localparam logic [CMD_W-1:0] CMD_ROM_READ   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CTRL_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RAM_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RAM_WRITE  = 2'd3;

   localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
   localparam logic [2:0] REGION_RAM_BANK   = 3'd2;

   localparam logic [3:0]            RAM_ENABLE_KEY = 4'hA;
   localparam logic [DATA_W-1:0]     RAM_OFF_DATA   = 8'hFF;
   localparam logic [CFG_W-1:0]      CFG_RESET      = 3'd5;
   localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 5'd1;

   typedef struct packed {
      logic [ROM_ADDR_W-1:0]  rom_address;
      logic                   address_error;
      logic                   is_ram_read;
      logic                   ram_enabled;
      logic                   ram_we;
      logic [RAM_INDEX_W-1:0] ram_index;
   } cbsm_dec_type;

   function automatic logic [ROM_BANK_W-1:0] rom_bank_select(
      input logic [DATA_W-1:0] value,
      input logic [CFG_W-1:0]  bank_bits
   );
      logic [ROM_BANK_W-1:0] bank;
      logic [CFG_W-1:0]      bits;
      logic [ROM_BANK_W:0]   mask;
      bank = value[ROM_BANK_W-1:0];
      bits = (bank_bits > CFG_W'(ROM_BANK_W)) ? CFG_W'(ROM_BANK_W) : bank_bits;
      if (bank == '0) begin
         bank = ROM_BANK_W'(1);
      end
      mask = (ROM_BANK_W+1)'(1) << bits;
      mask = mask - (ROM_BANK_W+1)'(1);
      return bank & mask[ROM_BANK_W-1:0];
   endfunction

endpackage

@@ rtl/core/cbsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbsm_ctrl
// Bank registers, control writes and address decode of one beat.
// ----------------------------------------------------------------------------
module cbsm_ctrl import cbsm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [CMD_W-1:0]     command,
   input  logic [ADDR_W-1:0]    address,
   input  logic [DATA_W-1:0]    value,
   input  logic                 csr_we,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cbsm_dec_type         dec
);

   logic [CFG_W-1:0]      rom_bank_bits_ff, rom_bank_bits_in;
   logic                  ram_enabled_ff, ram_enabled_in;
   logic [ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [RAM_BANK_W-1:0] ram_bank_ff, ram_bank_in;
   logic [RAM_SEL_W-1:0]  ram_sel;

   assign ram_sel = RAM_SEL_W'(ram_bank_ff % RAM_BANKS);

   always_comb begin
      dec             = '0;
      dec.ram_enabled = ram_enabled_ff;
      dec.ram_index   = {ram_sel, address[RAM_OFFSET_W-1:0]};
      unique case (command)
         CMD_ROM_READ: begin
            if (address[ADDR_W-1]) begin
               dec.address_error = 1'b1;
            end else if (address[ROM_OFFSET_W]) begin
               dec.rom_address = {rom_bank_ff, address[ROM_OFFSET_W-1:0]};
            end else begin
               dec.rom_address = {ROM_BANK_W'(0), address[ROM_OFFSET_W-1:0]};
            end
         end
         CMD_CTRL_WRITE: begin
            dec.ram_we = 1'b0;
         end
         CMD_RAM_READ: begin
            dec.is_ram_read = 1'b1;
         end
         CMD_RAM_WRITE: begin
            dec.ram_we = ram_enabled_ff;
         end
         default: begin
            dec.ram_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      rom_bank_bits_in = csr_we ? csr_wdata : rom_bank_bits_ff;
      ram_enabled_in   = ram_enabled_ff;
      rom_bank_in      = rom_bank_ff;
      ram_bank_in      = ram_bank_ff;
      if (accept && command == CMD_CTRL_WRITE) begin
         unique case (address[ADDR_W-1:ADDR_W-3])
            REGION_RAM_ENABLE: begin
               ram_enabled_in = (value[3:0] == RAM_ENABLE_KEY);
            end
            REGION_ROM_BANK: begin
               rom_bank_in = rom_bank_select(value, rom_bank_bits_ff);
            end
            REGION_RAM_BANK: begin
               ram_bank_in = value[RAM_BANK_W-1:0];
            end
            default: begin
               ram_bank_in = ram_bank_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_bits_ff <= CFG_RESET;
         ram_enabled_ff   <= 1'b0;
         rom_bank_ff      <= ROM_BANK_RESET;
         ram_bank_ff      <= '0;
      end else begin
         rom_bank_bits_ff <= rom_bank_bits_in;
         ram_enabled_ff   <= ram_enabled_in;
         rom_bank_ff      <= rom_bank_in;
         ram_bank_ff      <= ram_bank_in;
      end
   end

endmodule

@@ rtl/core/cbsm_ram.sv @@
// ----------------------------------------------------------------------------
// cbsm_ram
// Cartridge RAM, one write and one registered read port, zeroed after reset.
// ----------------------------------------------------------------------------
module cbsm_ram import cbsm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [RAM_INDEX_W-1:0] wr_index,
   input  logic [DATA_W-1:0]      wr_data,
   input  logic                   rd_en,
   input  logic [RAM_INDEX_W-1:0] rd_index,
   output logic [DATA_W-1:0]      rd_data,
   output logic                   busy
);

   logic [DATA_W-1:0]      mem [RAM_DEPTH];
   logic [DATA_W-1:0]      rd_data_ff;
   logic                   clear_busy_ff, clear_busy_in;
   logic [RAM_INDEX_W-1:0] clear_index_ff, clear_index_in;

   assign busy    = clear_busy_ff;
   assign rd_data = rd_data_ff;

   always_comb begin
      clear_busy_in  = clear_busy_ff;
      clear_index_in = clear_index_ff;
      if (clear_busy_ff) begin
         clear_index_in = clear_index_ff + RAM_INDEX_W'(1);
         if (clear_index_ff == RAM_INDEX_W'(RAM_DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff  <= 1'b1;
         clear_index_ff <= '0;
      end else begin
         clear_busy_ff  <= clear_busy_in;
         clear_index_ff <= clear_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clear_index_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_index] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_index];
      end
   end

endmodule

@@ rtl/core/cartridge_bank_switch_mapper.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_switch_mapper
// Cartridge ROM/RAM bank mapper: ROM address translation, bank control, RAM.
// ----------------------------------------------------------------------------
// pipeline: a taken request beat is registered in stage s1, then in the output stage
// throughput: one beat per cycle while rsp_tready is high and no RAM zeroing sweep runs
// reset: bank registers to defaults, then a RAM zeroing sweep over all 32768 bytes
// with req_tready low; csr writes are taken throughout
module cartridge_bank_switch_mapper import cbsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // address[15:0], value[23:16]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // rom_address[18:0], read_data[26:19], zero pad
   output logic [0:0]  rsp_tuser,   // address_error[0]
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata    // rom_bank_bits
);

   cbsm_dec_type          dec;
   logic                  accept;
   logic                  ram_busy;
   logic [DATA_W-1:0]     ram_rd_data;
   logic                  s1_advance;

   logic                  s1_valid_ff, s1_valid_in;
   logic [ROM_ADDR_W-1:0] s1_rom_address_ff;
   logic                  s1_error_ff;
   logic                  s1_is_read_ff;
   logic                  s1_ram_enabled_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [ROM_ADDR_W-1:0] out_rom_address_ff;
   logic [DATA_W-1:0]     out_read_data_ff, out_read_data_in;
   logic                  out_error_ff;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !ram_busy && (!s1_valid_ff || s1_advance);
   assign accept     = req_tvalid && req_tready;

   cbsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_tuser),
      .address   (req_tdata[ADDR_W-1:0]),
      .value     (req_tdata[ADDR_W+DATA_W-1:ADDR_W]),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .dec       (dec)
   );

   cbsm_ram u_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && dec.ram_we),
      .wr_index (dec.ram_index),
      .wr_data  (req_tdata[ADDR_W+DATA_W-1:ADDR_W]),
      .rd_en    (accept),
      .rd_index (dec.ram_index),
      .rd_data  (ram_rd_data),
      .busy     (ram_busy)
   );

   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !s1_advance);
      out_valid_in = s1_advance || (out_valid_ff && !rsp_tready);
      if (!s1_is_read_ff) begin
         out_read_data_in = '0;
      end else if (s1_ram_enabled_ff) begin
         out_read_data_in = ram_rd_data;
      end else begin
         out_read_data_in = RAM_OFF_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rom_address_ff <= dec.rom_address;
         s1_error_ff       <= dec.address_error;
         s1_is_read_ff     <= dec.is_ram_read;
         s1_ram_enabled_ff <= dec.ram_enabled;
      end
      if (s1_advance) begin
         out_rom_address_ff <= s1_rom_address_ff;
         out_read_data_ff   <= out_read_data_in;
         out_error_ff       <= s1_error_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_read_data_ff, out_rom_address_ff};
   assign rsp_tuser  = out_error_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      ram_busy |-> !req_tready)
      else $error("request taken during ram zeroing sweep");

   a_error_has_no_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[18:0] == 19'd0))
      else $error("address error beat carries a rom address");

   a_write_only_when_enabled: assert property (@(posedge clock) disable iff (reset)
      (accept && dec.ram_we) |-> dec.ram_enabled)
      else $error("ram write while ram disabled");

   a_stage_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |=> s1_valid_ff)
      else $error("pending beat lost under output stall");

endmodule

@@ tb/cartridge_bank_switch_mapper_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_switch_mapper_test
// Self-checking bench for the cartridge bank mapper. A directed burst walks
// the ROM windows, the control regions, RAM enable and the error range. Random
// phases then sweep every bank-bit setting under varied handshake pressure.
// Each response beat is compared with a cycle-free model of the mapper.
// ----------------------------------------------------------------------------
module cartridge_bank_switch_mapper_test;
   import cbsm_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 95;
   localparam int REPORT_LINES = 40;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] value;
   } access_type;

   typedef struct packed {
      logic [ROM_ADDR_W-1:0] rom_address;
      logic [DATA_W-1:0]     read_data;
      logic                  address_error;
   } mapping_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_wdata  = '0;

   // model state
   logic                  model_ram_on;
   logic [ROM_BANK_W-1:0] model_rom_bank;
   logic [RAM_BANK_W-1:0] model_ram_bank;
   logic [CFG_W-1:0]      model_bank_bits;
   logic [DATA_W-1:0]     ram_image [RAM_DEPTH];

   access_type    access_queue[$];
   mapping_type   expected_maps[$];
   idle_mode_type idle_mode   = IDLE_NONE;
   int            hold_cycles = 0;
   bit            beat_taken  = 1'b0;
   int            cycle_count = 0;
   int            mismatch_count = 0;
   int            beats_checked  = 0;
   int            command_count[4] = '{default: 0};
   int            error_count      = 0;
   int            settings_seen    = 0;

   cartridge_bank_switch_mapper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic mapping_type map_access(input access_type a);
      mapping_type           m;
      logic [ROM_BANK_W-1:0] bank;
      int                    width;
      logic [RAM_INDEX_W-1:0] slot;
      m = '0;
      slot = {model_ram_bank[RAM_SEL_W-1:0], a.address[RAM_OFFSET_W-1:0]};
      case (a.command)
         CMD_ROM_READ: begin
            if (a.address < 16'h4000) begin
               m.rom_address = ROM_ADDR_W'(a.address);
            end else if (a.address < 16'h8000) begin
               m.rom_address = {model_rom_bank, a.address[ROM_OFFSET_W-1:0]};
            end else begin
               m.address_error = 1'b1;
            end
         end
         CMD_CTRL_WRITE: begin
            if (a.address < 16'h2000) begin
               model_ram_on = (a.value[3:0] == RAM_ENABLE_KEY);
            end else if (a.address < 16'h4000) begin
               width = (model_bank_bits > ROM_BANK_W) ? ROM_BANK_W : int'(model_bank_bits);
               bank = a.value[ROM_BANK_W-1:0];
               if (bank == '0) begin
                  bank = ROM_BANK_W'(1);
               end
               model_rom_bank = bank & ROM_BANK_W'((1 << width) - 1);
            end else if (a.address < 16'h6000) begin
               model_ram_bank = a.value[RAM_BANK_W-1:0];
            end
         end
         CMD_RAM_READ: begin
            m.read_data = model_ram_on ? ram_image[slot] : RAM_OFF_DATA;
         end
         default: begin
            if (model_ram_on) begin
               ram_image[slot] = a.value;
            end
         end
      endcase
      return m;
   endfunction

   function automatic bit sender_idles();
      return (idle_mode == IDLE_SEND && $urandom_range(99) < 87) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 13);
   endfunction

   function automatic bit receiver_stalls();
      return (idle_mode == IDLE_RECV && $urandom_range(99) < 87) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 13);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LINES) begin
         $display("[%0t] mismatch on response beat %0d: %s", $realtime, beats_checked, what);
      end
      mismatch_count++;
   endtask

   task automatic queue_access(input logic [CMD_W-1:0] command,
                               input logic [ADDR_W-1:0] address,
                               input logic [DATA_W-1:0] value);
      access_type a;
      a.command = command;
      a.address = address;
      a.value   = value;
      access_queue.push_back(a);
   endtask

   task automatic queue_random(input int count);
      access_type a;
      int         pick;
      repeat (count) begin
         pick = $urandom_range(99);
         a.value = DATA_W'($urandom_range(255));
         if (pick < 30) begin
            a.command = CMD_ROM_READ;
            a.address = (pick < 26) ? ADDR_W'($urandom_range(16'h7FFF))
                                    : ADDR_W'($urandom_range(16'hFFFF));
         end else if (pick < 55) begin
            a.command = CMD_CTRL_WRITE;
            case ($urandom_range(3))
               0: begin
                  a.address = ADDR_W'($urandom_range(16'h1FFF));
                  if ($urandom_range(99) < 80) begin
                     a.value[3:0] = RAM_ENABLE_KEY;
                  end
               end
               1: a.address = ADDR_W'($urandom_range(16'h3FFF, 16'h2000));
               2: a.address = ADDR_W'($urandom_range(16'h5FFF, 16'h4000));
               default: a.address = ADDR_W'($urandom_range(16'hFFFF, 16'h6000));
            endcase
         end else begin
            a.command = (pick < 80) ? CMD_RAM_READ : CMD_RAM_WRITE;
            a.address[15:13] = 3'($urandom_range(7));
            a.address[12:0]  = ($urandom_range(99) < 70) ? 13'($urandom_range(31))
                                                         : 13'($urandom_range(8191));
         end
         access_queue.push_back(a);
      end
   endtask

   task automatic wait_drained();
      while (access_queue.size() > 0 || expected_maps.size() > 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bank_bits(input logic [CFG_W-1:0] bits);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= bits;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      settings_seen++;
   endtask

   // request side
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || beat_taken) begin
         if (access_queue.size() > 0 && !sender_idles()) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {access_queue[0].value, access_queue[0].address};
            req_tuser  <= access_queue[0].command;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      beat_taken = 1'b0;
   end

   // response side back-pressure, long hold-off counted here
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= !receiver_stalls();
      end
   end

   // beat monitor and prediction
   always @(posedge clock) begin
      access_type  a;
      mapping_type e;
      if (csr_we) begin
         model_bank_bits = csr_wdata;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_maps.size() == 0) begin
               report_mismatch("response beat with nothing outstanding");
            end else begin
               e = expected_maps.pop_front();
               if (rsp_tdata[18:0] !== e.rom_address) begin
                  report_mismatch($sformatf("rom_address %h, want %h",
                                            rsp_tdata[18:0], e.rom_address));
               end
               if (rsp_tdata[26:19] !== e.read_data) begin
                  report_mismatch($sformatf("read_data %h, want %h",
                                            rsp_tdata[26:19], e.read_data));
               end
               if (rsp_tuser[0] !== e.address_error) begin
                  report_mismatch($sformatf("address_error %b, want %b",
                                            rsp_tuser[0], e.address_error));
               end
            end
            beats_checked++;
         end
         if (req_tvalid && req_tready) begin
            void'(access_queue.pop_front());
            a.command = req_tuser;
            a.address = req_tdata[15:0];
            a.value   = req_tdata[23:16];
            e = map_access(a);
            expected_maps.push_back(e);
            command_count[a.command]++;
            if (e.address_error) begin
               error_count++;
            end
            beat_taken = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_maps.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [CFG_W-1:0] bits_plan[9];
      bits_plan       = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd2, 3'd4, 3'd5, 3'd0};
      model_ram_on    = 1'b0;
      model_rom_bank  = ROM_BANK_RESET;
      model_ram_bank  = '0;
      model_bank_bits = CFG_RESET;
      ram_image       = '{default: '0};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rom windows, disabled ram, enable key, bank extremes, ignored range
      queue_access(CMD_ROM_READ,   16'h0000, 8'h00);
      queue_access(CMD_ROM_READ,   16'h3FFF, 8'hFF);
      queue_access(CMD_ROM_READ,   16'h4000, 8'h00);
      queue_access(CMD_ROM_READ,   16'h8000, 8'h00);
      queue_access(CMD_ROM_READ,   16'hFFFF, 8'h00);
      queue_access(CMD_RAM_WRITE,  16'h0005, 8'h5A);
      queue_access(CMD_RAM_READ,   16'h0005, 8'h00);
      queue_access(CMD_CTRL_WRITE, 16'h0000, 8'h0A);
      queue_access(CMD_RAM_READ,   16'h0005, 8'h00);
      queue_access(CMD_RAM_WRITE,  16'hFFFF, 8'hFF);
      queue_access(CMD_RAM_READ,   16'h1FFF, 8'h00);
      queue_access(CMD_CTRL_WRITE, 16'h2000, 8'h00);
      queue_access(CMD_ROM_READ,   16'h4001, 8'h00);
      queue_access(CMD_CTRL_WRITE, 16'h3FFF, 8'hFF);
      queue_access(CMD_ROM_READ,   16'h7FFF, 8'h00);
      queue_access(CMD_CTRL_WRITE, 16'h5FFF, 8'hFF);
      queue_access(CMD_RAM_READ,   16'hE000, 8'h00);
      queue_access(CMD_CTRL_WRITE, 16'h4000, 8'h00);
      queue_access(CMD_RAM_READ,   16'h1FFF, 8'h00);
      queue_access(CMD_CTRL_WRITE, 16'h6000, 8'h00);
      queue_access(CMD_CTRL_WRITE, 16'hFFFF, 8'h03);
      queue_access(CMD_ROM_READ,   16'h7FFF, 8'h00);
      queue_access(CMD_CTRL_WRITE, 16'h1FFF, 8'hFB);
      queue_access(CMD_RAM_READ,   16'h1FFF, 8'h00);
      queue_access(CMD_CTRL_WRITE, 16'h1000, 8'h3A);
      wait_drained();

      for (int p = 0; p < 9; p++) begin
         write_bank_bits(bits_plan[p]);
         idle_mode = idle_mode_type'(p % 4);
         if (p == 4) begin
            hold_cycles = 400;
         end
         // bank write straight after a new mask, then random traffic
         queue_access(CMD_CTRL_WRITE, 16'h2000, 8'(p * 7 + 3));
         queue_access(CMD_ROM_READ, 16'h4000 + 16'(p), 8'h00);
         queue_random(PHASE_ITEMS);
         wait_drained();
      end

      $display("checked %0d beats: %0d rom reads (%0d out of range), %0d control writes,",
               beats_checked, command_count[CMD_ROM_READ], error_count,
               command_count[CMD_CTRL_WRITE]);
      $display("%0d ram reads, %0d ram writes over %0d bank-bit settings",
               command_count[CMD_RAM_READ], command_count[CMD_RAM_WRITE], settings_seen);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/cbsm_pkg.sv
rtl/core/cbsm_ctrl.sv
rtl/core/cbsm_ram.sv
rtl/core/cartridge_bank_switch_mapper.sv
tb/cartridge_bank_switch_mapper_test.sv
